// File: src/adcm_pkg.sv
package adcm_pkg;

  localparam int XW = 56;
  localparam int ZW = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS = 47;
  localparam int MUL_STEPS = 18;

  localparam logic CMD_DRIVE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [2:0] REG_WHEEL_RADIUS = 3'd0;
  localparam logic [2:0] REG_WHEEL_BASE   = 3'd1;
  localparam logic [2:0] REG_TRACK_WIDTH  = 3'd2;
  localparam logic [2:0] REG_MIN_SPEED    = 3'd3;
  localparam logic [2:0] REG_MAX_SPEED    = 3'd4;

  localparam logic signed [31:0] STEER_LIMIT = 32'sd19445;
  localparam logic [15:0] STEER_DEAD = 16'd1310;
  localparam logic [19:0] PHASE_STEP = 20'd2621;
  localparam logic [19:0] TWO_PI_Q = 20'd411775;
  localparam logic signed [20:0] TWO_PI_S = 21'sd411775;
  localparam logic signed [20:0] PI_S = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_S = 21'sd102944;
  localparam logic [17:0] HALF_PI_A = 18'd102944;
  localparam logic [17:0] WIGGLE_GAIN = 18'd6488;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 56'sh26DD3B6A;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_DIVEND, ST_WSIN, ST_WMUL_T, ST_WMUL_M, ST_ANG,
    ST_ANG_WAIT, ST_MUL_Y, ST_MUL_C, ST_MUL_W, ST_VSET, ST_VRUN, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic vector;
  } cordic_ctl_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h3243F6A8;
      5'd1: v = 32'h1DAC6705;
      5'd2: v = 32'h0FADBAFC;
      5'd3: v = 32'h07F56EA6;
      5'd4: v = 32'h03FEAB76;
      5'd5: v = 32'h01FFD55B;
      5'd6: v = 32'h00FFFAAA;
      5'd7: v = 32'h007FFF55;
      5'd8: v = 32'h003FFFEA;
      5'd9: v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      default: v = 32'h0;
    endcase
    return {2'b00, v};
  endfunction

endpackage

// File: src/ackermann_drive_command_mapper_top.sv
// A drive command request stores speed and steering when it is accepted and returns
// no result. An update tick gives one result, in normal or in rotation-only mode. A
// 47-step restoring divider forms speed (max speed in rotation-only mode) over wheel
// radius. One shared 30-step CORDIC unit computes the sine and cosine of the wiggle
// phase (in rotation-only mode) and of the steering angle, and then both wheel
// arctangents. An 18-step shift-add multiplier forms every product. Straight
// steering skips the angle work. An arctangent with a zero operand skips its CORDIC
// run. The input is not ready while a tick is in progress; a finished result waits
// in the output register while the next request is taken.
module ackermann_drive_command_mapper_top
  import adcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // speed_request[31:0], steer_request[63:32]
  input  logic        s_tuser,  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // wheel_rate, right_angle, left_angle, brake, zero pad
);

  state_t state, state_next;

  logic [30:0] wheel_radius, wheel_base, track_width, min_speed, max_speed;
  logic signed [31:0] held_speed, held_steer;
  logic [18:0] phase;

  logic signed [15:0] st;
  logic brake_r, rot_r, spd_neg, pass, sneg;
  logic signed [19:0] wig_ang;
  logic [46:0] dnum, q;
  logic [30:0] drem;
  logic [5:0] dcnt;
  logic dzero;
  logic [63:0] mcand, prod, prod_step;
  logic [17:0] mplier, mag16, cmag;
  logic [4:0] mcnt;
  logic [31:0] rate;
  logic signed [XW-1:0] ys, lc, ws;
  logic signed [17:0] inner, outer;

  cordic_ctl_t cctl;
  logic signed [XW-1:0] cx0, cy0, cx, cy;
  logic signed [ZW-1:0] cz0, cz;
  logic cdone;

  logic signed [31:0] sp;
  logic [31:0] sp_mag, spd_lim, hs_abs;
  logic signed [31:0] st_wide;
  logic signed [15:0] st_c;
  logic [15:0] ast;
  logic low, rot;
  logic [19:0] ph_sum, ph_wrap;
  logic signed [20:0] p0, p1, p2;
  logic [30:0] num;
  logic [31:0] dr;
  logic dge;
  logic [46:0] q_val;
  logic signed [41:0] s16w, c16w, s_abs, c_abs;
  logic signed [XW-1:0] vx_raw, vx, vy;
  logic vspecial;
  logic signed [17:0] vres, zres;
  logic signed [ZW-1:0] zr;
  logic [15:0] st_abs;
  logic signed [17:0] right_o, left_o;
  logic [31:0] wig_rate;
  logic mul_last;

  function automatic logic [31:0] sat_rate(input logic neg, input logic [47:0] mag);
    logic big;
    big = |mag[47:31];
    if (neg) return big ? 32'h80000000 : 32'(-mag[31:0]);
    return big ? 32'h7FFFFFFF : mag[31:0];
  endfunction

  adcm_cordic u_cordic (
    .clk(clk), .rst(rst), .ctl(cctl), .x0(cx0), .y0(cy0), .z0(cz0),
    .done(cdone), .x(cx), .y(cy), .z(cz)
  );

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    sp = s_tdata[31:0];
    sp_mag = sp[31] ? 32'(-sp) : 32'(sp);
    spd_lim = sp_mag;
    if (sp_mag != 32'd0 && sp_mag < {1'b0, min_speed}) spd_lim = {1'b0, min_speed};
    if (spd_lim > {1'b0, max_speed}) spd_lim = {1'b0, max_speed};

    st_wide = held_steer;
    if (held_steer > STEER_LIMIT) st_wide = STEER_LIMIT;
    if (held_steer < -STEER_LIMIT) st_wide = -STEER_LIMIT;
    st_c = st_wide[15:0];
    ast = st_c[15] ? 16'(-st_c) : 16'(st_c);
    hs_abs = held_speed[31] ? 32'(-held_speed) : 32'(held_speed);
    low = {hs_abs[30:0], 1'b0} < {1'b0, min_speed};
    rot = low && (ast > STEER_DEAD);

    ph_sum = {1'b0, phase} + PHASE_STEP;
    ph_wrap = (ph_sum >= TWO_PI_Q) ? ph_sum - TWO_PI_Q : ph_sum;
    p0 = {1'b0, ph_wrap};
    if (p0 >= PI_S) p0 = p0 - TWO_PI_S;
    p1 = (p0 > HALF_PI_S) ? PI_S - p0 : p0;
    p2 = (p1 < -HALF_PI_S) ? -PI_S - p1 : p1;
    num = rot ? max_speed : hs_abs[30:0];

    dr = {drem, dnum[46]};
    dge = dr >= {1'b0, wheel_radius};
    q_val = dzero ? 47'd0 : dnum;

    prod_step = prod + (mplier[0] ? mcand : 64'd0);
    mul_last = (mcnt == 5'(MUL_STEPS - 1));
    wig_rate = sat_rate(sneg, prod_step[63:16]);

    s16w = cy[XW-1:14];
    c16w = cx[XW-1:14];
    s_abs = s16w[41] ? -s16w : s16w;
    c_abs = c16w[41] ? -c16w : c16w;
    st_abs = st[15] ? 16'(-st) : 16'(st);

    vx_raw = pass ? lc + ws : lc - ws;
    vx = vx_raw[XW-1] ? -vx_raw : vx_raw;
    vy = vx_raw[XW-1] ? -ys : ys;
    vspecial = (vy == '0) || (vx == '0);
    if (vy == '0) vres = '0;
    else if (vy[XW-1]) vres = -$signed(HALF_PI_A);
    else vres = $signed(HALF_PI_A);
    zr = cz + 34'sd8192;
    zres = zr[31:14];

    if (st == 16'sd0) begin
      right_o = '0;
      left_o = '0;
    end else if (!st[15]) begin
      right_o = outer;
      left_o = inner;
    end else begin
      right_o = -inner;
      left_o = -outer;
    end
  end

  always_comb begin
    state_next = state;
    cctl = '0;
    cx0 = CORDIC_GAIN;
    cy0 = '0;
    cz0 = {wig_ang, 14'b0};
    case (state)
      ST_IDLE: if (s_tvalid && s_tuser == CMD_TICK) state_next = ST_DIV;
      ST_DIV: if (dcnt == 6'(DIV_STEPS - 1)) state_next = ST_DIVEND;
      ST_DIVEND: begin
        if (rot_r) begin
          cctl.start = 1'b1;
          state_next = ST_WSIN;
        end else begin
          state_next = ST_ANG;
        end
      end
      ST_WSIN: if (cdone) state_next = ST_WMUL_T;
      ST_WMUL_T: if (mul_last) state_next = ST_WMUL_M;
      ST_WMUL_M: if (mul_last) state_next = ST_ANG;
      ST_ANG: begin
        cz0 = {4'b0, st_abs[15:0], 14'b0};
        if (st == 16'sd0) begin
          state_next = ST_OUT;
        end else begin
          cctl.start = 1'b1;
          state_next = ST_ANG_WAIT;
        end
      end
      ST_ANG_WAIT: if (cdone) state_next = ST_MUL_Y;
      ST_MUL_Y: if (mul_last) state_next = ST_MUL_C;
      ST_MUL_C: if (mul_last) state_next = ST_MUL_W;
      ST_MUL_W: if (mul_last) state_next = ST_VSET;
      ST_VSET: begin
        cx0 = vx;
        cy0 = vy;
        cz0 = '0;
        if (vspecial) begin
          state_next = pass ? ST_OUT : ST_VSET;
        end else begin
          cctl.start = 1'b1;
          cctl.vector = 1'b1;
          state_next = ST_VRUN;
        end
      end
      ST_VRUN: if (cdone) state_next = pass ? ST_OUT : ST_VSET;
      ST_OUT: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      held_speed <= '0;
      held_steer <= '0;
      phase <= '0;
      wheel_radius <= 31'd1900;
      wheel_base <= 31'd10879;
      track_width <= 31'd11141;
      min_speed <= 31'd0;
      max_speed <= 31'd78643;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_WHEEL_RADIUS: wheel_radius <= cfg_data;
          REG_WHEEL_BASE: wheel_base <= cfg_data;
          REG_TRACK_WIDTH: track_width <= cfg_data;
          REG_MIN_SPEED: min_speed <= cfg_data;
          REG_MAX_SPEED: max_speed <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_IDLE && s_tvalid) begin
        if (s_tuser == CMD_DRIVE) begin
          held_speed <= sp[31] ? 32'(-spd_lim) : 32'(spd_lim);
          held_steer <= s_tdata[63:32];
        end else if (rot) begin
          phase <= ph_wrap[18:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        st <= st_c;
        rot_r <= rot;
        brake_r <= low && !rot;
        spd_neg <= held_speed[31];
        wig_ang <= p2[19:0];
        dnum <= {num, 16'b0};
        drem <= '0;
        dcnt <= '0;
        dzero <= (num == 31'd0);
      end
      ST_DIV: begin
        drem <= dge ? 31'(dr - {1'b0, wheel_radius}) : dr[30:0];
        dnum <= {dnum[45:0], dge};
        dcnt <= dcnt + 6'd1;
      end
      ST_DIVEND: begin
        q <= q_val;
        rate <= sat_rate(spd_neg, {1'b0, q_val});
      end
      ST_WSIN: begin
        sneg <= s16w[41];
        mag16 <= s_abs[17:0];
        mcand <= {17'b0, q};
        mplier <= WIGGLE_GAIN;
        prod <= '0;
        mcnt <= '0;
      end
      ST_ANG: begin
        pass <= 1'b0;
        inner <= '0;
        outer <= '0;
      end
      ST_ANG_WAIT: begin
        sneg <= s16w[41];
        mag16 <= s_abs[17:0];
        cmag <= c_abs[17:0];
        mcand <= {32'b0, wheel_base, 1'b0};
        mplier <= s_abs[17:0];
        prod <= '0;
        mcnt <= '0;
      end
      ST_WMUL_T, ST_WMUL_M, ST_MUL_Y, ST_MUL_C, ST_MUL_W: begin
        if (mul_last) begin
          prod <= '0;
          mcnt <= '0;
          case (state)
            ST_WMUL_T: begin
              mcand <= {16'b0, prod_step[63:16]};
              mplier <= mag16;
            end
            ST_WMUL_M: begin
              rate <= wig_rate;
              if (wig_rate[31]) st <= -st;
            end
            ST_MUL_Y: begin
              ys <= sneg ? -$signed(prod_step[XW-1:0]) : $signed(prod_step[XW-1:0]);
              mcand <= {32'b0, wheel_base, 1'b0};
              mplier <= cmag;
            end
            ST_MUL_C: begin
              lc <= $signed(prod_step[XW-1:0]);
              mcand <= {33'b0, track_width};
              mplier <= mag16;
            end
            default: begin
              ws <= sneg ? -$signed(prod_step[XW-1:0]) : $signed(prod_step[XW-1:0]);
            end
          endcase
        end else begin
          prod <= prod_step;
          mcand <= {mcand[62:0], 1'b0};
          mplier <= {1'b0, mplier[17:1]};
          mcnt <= mcnt + 5'd1;
        end
      end
      ST_VSET: begin
        if (vspecial) begin
          if (pass) outer <= vres;
          else inner <= vres;
          pass <= 1'b1;
        end
      end
      ST_VRUN: begin
        if (cdone) begin
          if (pass) outer <= zres;
          else inner <= zres;
          pass <= 1'b1;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {3'b0, brake_r, left_o, right_o, rate};
        end
      end
      default: ;
    endcase
  end

endmodule

// File: src/adcm_cordic.sv
module adcm_cordic
  import adcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cordic_ctl_t          ctl,
  input  logic signed [XW-1:0] x0,
  input  logic signed [XW-1:0] y0,
  input  logic signed [ZW-1:0] z0,
  output logic                 done,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output logic signed [ZW-1:0] z
);

  logic busy;
  logic vector;
  logic [4:0] cnt;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] da;
  logic pos;

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign da = atan_entry(cnt);
  assign pos = vector ? y[XW-1] : !z[ZW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x <= x0;
      y <= y0;
      z <= z0;
      vector <= ctl.vector;
    end else if (busy) begin
      if (pos) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
    end
  end

endmodule

// File: src/adcm_checker.sv
module adcm_checker
  import adcm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_TICK) |=> !s_tready ##1 !s_tready)
    else $error("Input ready too soon after a tick request.");

  a_drive_quick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_DRIVE) |=> s_tready)
    else $error("Drive request did not complete in one cycle.");

  a_result_in_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("Result appeared without a tick in progress.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("Stalled result changed.");

endmodule

bind ackermann_drive_command_mapper_top adcm_checker u_adcm_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
